/* rtl/timestamped_position_history_lerp_assert.svh */
// Assertion macros for the position history block.
`ifndef TIMESTAMPED_POSITION_HISTORY_LERP_ASSERT_SVH
`define TIMESTAMPED_POSITION_HISTORY_LERP_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define TPH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define TPH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/tphl_pkg.sv */
// Package: payload types, constants and sequencer states for the position history.
package tphl_pkg;
  localparam int unsigned DepthDefault = 64;
  localparam logic [31:0] MaxAgeReset = 32'd1000000;
  localparam logic ModeRecord = 1'b0;
  localparam logic ModeQuery  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic        [31:0] sample_time;
    logic        [31:0] now_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               history_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_Q_RD0,
    ST_Q_CHK0,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DIV,
    ST_MUL,
    ST_LAST_RD,
    ST_LAST_LD,
    ST_OUT
  } state_t;
endpackage

/* rtl/timestamped_position_history_lerp.sv */
// Top level: timestamped 3-D position history with linear interpolation on query.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------
//  in      | input     | in_valid/in_stall| tphl_pkg::in_item_t
//  out     | output    | out_valid/out_stall | tphl_pkg::out_item_t
//  cfg     | input     | cfg_valid/cfg_ready | max_age, 32 bit
//
// A record writes its entry, then drops the oldest entry while its age
// exceeds max_age. A query compares the scanned pairs one at a time
// (one memory read port, one compare), then runs 48 divider steps (one
// quotient bit per cycle) and a multiply per axis on one 33x17 multiplier.
// Reset: rst is synchronous; it empties the ring and loads max_age = 1000000.
// No memory clear is needed. The result sits in an output register until taken;
// the next transaction is accepted only after that.
`include "timestamped_position_history_lerp_assert.svh"
module timestamped_position_history_lerp #(
  parameter int unsigned DEPTH = tphl_pkg::DepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tphl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tphl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Ring storage, one word per entry: time, x, y, z.
  logic [127:0] mem [DEPTH];
  logic [127:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_data.sample_time, in_data.pos_x, in_data.pos_y,
                                in_data.pos_z};
    rd_data <= mem[rd_addr];
  end

  tphl_pkg::state_t state, state_next;
  logic [31:0] max_age;
  logic [AW-1:0] oldest_index, oldest_index_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [CW-1:0] k, k_next;
  logic [31:0] qtime, qtime_next;
  logic [31:0] now_r, now_r_next;
  logic [127:0] ent_a, ent_a_next;      // lower entry of a pair
  logic [31:0] den, den_next;
  logic [47:0] rem, rem_next;            // divider remainder / numerator shift
  logic [47:0] num, num_next;
  logic [15:0] alpha, alpha_next;
  logic [5:0]  step, step_next;
  logic [1:0]  axis, axis_next;
  tphl_pkg::out_item_t res, res_next;
  logic        out_valid_r, out_valid_next;

  // Slot of the k-th entry from oldest.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] kk);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, kk[AW-1:0]};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // Shared lerp multiplier: one axis per cycle.
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [31:0] p0, p1, lerp_out;
  always_comb begin
    unique case (axis)
      2'd0: begin p0 = ent_a[95:64]; p1 = rd_data[95:64]; end
      2'd1: begin p0 = ent_a[63:32]; p1 = rd_data[63:32]; end
      default: begin p0 = ent_a[31:0]; p1 = rd_data[31:0]; end
    endcase
    diff = 33'(p1) - 33'(p0);
    prod = 50'(diff) * $signed({34'd0, alpha});
    lerp_out = p0 + 32'((prod + 50'sd32768) >>> 16);
  end

  // Divider trial subtract.
  logic [48:0] trial;
  assign trial = {rem[47:0], num[47]} - {17'd0, den};

  always_comb begin
    state_next = state;
    oldest_index_next = oldest_index;
    entry_count_next = entry_count;
    k_next = k;
    qtime_next = qtime;
    now_r_next = now_r;
    ent_a_next = ent_a;
    den_next = den;
    rem_next = rem;
    num_next = num;
    alpha_next = alpha;
    step_next = step;
    axis_next = axis;
    res_next = res;
    out_valid_next = out_valid_r && out_stall;
    wr_en = 1'b0;
    wr_addr = slot(oldest_index, entry_count);
    rd_addr = slot(oldest_index, k);
    unique case (state)
      tphl_pkg::ST_IDLE: begin
        k_next = '0;
        if (in_valid && !out_valid_r) begin
          qtime_next = in_data.sample_time;
          now_r_next = in_data.now_time;
          if (in_data.mode == tphl_pkg::ModeRecord) begin
            wr_en = 1'b1;
            if (entry_count == CW'(DEPTH)) begin
              wr_addr = oldest_index;
              oldest_index_next = slot(oldest_index, CW'(1));
            end else begin
              entry_count_next = entry_count + 1'b1;
            end
            state_next = tphl_pkg::ST_AGE_RD;
          end else if (entry_count == '0) begin
            res_next = '{out_x: '0, out_y: '0, out_z: '0, history_empty: 1'b1};
            state_next = tphl_pkg::ST_OUT;
          end else begin
            state_next = tphl_pkg::ST_Q_RD0;
          end
        end
      end
      tphl_pkg::ST_AGE_RD: begin
        if (entry_count == '0) state_next = tphl_pkg::ST_IDLE;
        else state_next = tphl_pkg::ST_AGE_CHK;
      end
      tphl_pkg::ST_AGE_CHK: begin
        if (now_r >= rd_data[127:96] && (now_r - rd_data[127:96]) > max_age) begin
          oldest_index_next = slot(oldest_index, CW'(1));
          entry_count_next = entry_count - 1'b1;
          state_next = tphl_pkg::ST_AGE_RD;
        end else begin
          state_next = tphl_pkg::ST_IDLE;
        end
      end
      tphl_pkg::ST_Q_RD0: state_next = tphl_pkg::ST_Q_CHK0;
      tphl_pkg::ST_Q_CHK0: begin
        ent_a_next = rd_data;
        if (qtime <= rd_data[127:96]) begin
          res_next = '{out_x: rd_data[95:64], out_y: rd_data[63:32],
                       out_z: rd_data[31:0], history_empty: 1'b0};
          state_next = tphl_pkg::ST_OUT;
        end else begin
          k_next = k + 1'b1;
          rd_addr = slot(oldest_index, k + 1'b1);
          state_next = (k + 1'b1 < entry_count) ? tphl_pkg::ST_SCAN_CHK
                                               : tphl_pkg::ST_LAST_RD;
        end
      end
      tphl_pkg::ST_SCAN_CHK: begin
        // ent_a is entry k-1, rd_data is entry k
        if (qtime >= ent_a[127:96] && qtime < rd_data[127:96]) begin
          den_next = rd_data[127:96] - ent_a[127:96];
          num_next = {qtime - ent_a[127:96], 16'd0};
          rem_next = '0;
          step_next = '0;
          state_next = tphl_pkg::ST_DIV;
        end else begin
          ent_a_next = rd_data;
          k_next = k + 1'b1;
          rd_addr = slot(oldest_index, k + 1'b1);
          state_next = (k + 1'b1 < entry_count) ? tphl_pkg::ST_SCAN_RD
                                               : tphl_pkg::ST_LAST_RD;
        end
      end
      tphl_pkg::ST_SCAN_RD: state_next = tphl_pkg::ST_SCAN_CHK;
      tphl_pkg::ST_DIV: begin
        // Restoring divide, one quotient bit per cycle; rd_data holds entry k.
        rd_addr = slot(oldest_index, k);
        num_next = {num[46:0], 1'b0};
        if (!trial[48]) begin
          rem_next = trial[47:0];
          alpha_next = {alpha[14:0], 1'b1};
        end else begin
          rem_next = {rem[46:0], num[47]};
          alpha_next = {alpha[14:0], 1'b0};
        end
        step_next = step + 1'b1;
        if (step == 6'd47) begin
          axis_next = 2'd0;
          state_next = tphl_pkg::ST_MUL;
        end
      end
      tphl_pkg::ST_MUL: begin
        rd_addr = slot(oldest_index, k);
        axis_next = axis + 1'b1;
        unique case (axis)
          2'd0: res_next.out_x = lerp_out;
          2'd1: res_next.out_y = lerp_out;
          default: res_next.out_z = lerp_out;
        endcase
        res_next.history_empty = 1'b0;
        if (axis == 2'd2) state_next = tphl_pkg::ST_OUT;
      end
      tphl_pkg::ST_LAST_RD: begin
        rd_addr = slot(oldest_index, entry_count - 1'b1);
        state_next = tphl_pkg::ST_LAST_LD;
      end
      tphl_pkg::ST_LAST_LD: begin
        res_next = '{out_x: rd_data[95:64], out_y: rd_data[63:32],
                     out_z: rd_data[31:0], history_empty: 1'b0};
        state_next = tphl_pkg::ST_OUT;
      end
      tphl_pkg::ST_OUT: begin
        out_valid_next = 1'b1;
        state_next = tphl_pkg::ST_IDLE;
      end
      default: state_next = tphl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tphl_pkg::ST_IDLE;
      oldest_index <= '0;
      entry_count <= '0;
      out_valid_r <= 1'b0;
      max_age <= tphl_pkg::MaxAgeReset;
    end else begin
      state <= state_next;
      oldest_index <= oldest_index_next;
      entry_count <= entry_count_next;
      out_valid_r <= out_valid_next;
      if (cfg_valid && cfg_ready) max_age <= cfg_data;
    end
    k <= k_next;
    qtime <= qtime_next;
    now_r <= now_r_next;
    ent_a <= ent_a_next;
    den <= den_next;
    rem <= rem_next;
    num <= num_next;
    alpha <= alpha_next;
    step <= step_next;
    axis <= axis_next;
    res <= res_next;
  end

  assign in_stall = (state != tphl_pkg::ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = res;
  assign cfg_ready = 1'b1;

  `TPH_ASSERT_IMP(a_count_range, clk, rst, 1'b1, entry_count <= CW'(DEPTH), "count overflow")
  `TPH_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result dropped")
  `TPH_ASSERT_IMP(a_busy_stall, clk, rst, state != tphl_pkg::ST_IDLE, in_stall, "accept while busy")
endmodule

/* dv/timestamped_position_history_lerp_tb.sv */
// Testbench for the position history block: directed table, a ring fill, then random traffic.
module timestamped_position_history_lerp_tb;

  localparam int HistDepth = tphl_pkg::DepthDefault;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  tphl_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  tphl_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  timestamped_position_history_lerp uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: our own copy of the ring and the age limit.
  logic [31:0] ring_time [HistDepth];
  logic [31:0] ring_x [HistDepth];
  logic [31:0] ring_y [HistDepth];
  logic [31:0] ring_z [HistDepth];
  int unsigned head_slot;
  int unsigned fill;
  logic [31:0] age_limit;

  tphl_pkg::out_item_t expected_positions[$];
  int unsigned error_count;
  int unsigned stall_hold;      // long receiver hold-off, in cycles
  bit stall_randomly;

  // Directed table: item plus optional typed-in expectation.
  typedef struct {
    tphl_pkg::in_item_t  item;
    bit                  has_fixed;
    tphl_pkg::out_item_t fixed;
  } directed_row_t;

  function automatic int unsigned ring_slot(int unsigned k);
    return (head_slot + k) % HistDepth;
  endfunction

  function automatic logic [31:0] blend_axis(logic [31:0] a, logic [31:0] b,
                                             logic [15:0] alpha);
    longint p0;
    longint diff;
    longint prod;
    longint q;
    p0 = longint'($signed(a));
    diff = longint'($signed(b)) - p0;
    prod = diff * longint'({1'b0, alpha}) + 32768;
    q = prod >>> 16;
    return 32'(p0 + q);
  endfunction

  // Applies one accepted item to the predictor; queues the position a query returns.
  function automatic void predict_history(tphl_pkg::in_item_t it);
    tphl_pkg::out_item_t r;
    logic [31:0] t;
    logic [31:0] age;
    logic [63:0] num;
    logic [63:0] den;
    logic [15:0] alpha;
    int unsigned a;
    int unsigned b;
    bit found;
    t = it.sample_time;
    if (it.mode == tphl_pkg::ModeRecord) begin
      if (fill >= HistDepth) begin
        head_slot = ring_slot(1);
        fill--;
      end
      a = ring_slot(fill);
      ring_time[a] = t;
      ring_x[a] = it.pos_x;
      ring_y[a] = it.pos_y;
      ring_z[a] = it.pos_z;
      fill++;
      while (fill > 0) begin
        age = (it.now_time >= ring_time[head_slot]) ?
              it.now_time - ring_time[head_slot] : 32'd0;
        if (age > age_limit) begin
          head_slot = ring_slot(1);
          fill--;
        end else break;
      end
      return;
    end
    r = '0;
    if (fill == 0) begin
      r.history_empty = 1'b1;
    end else if (t <= ring_time[head_slot]) begin
      r.out_x = ring_x[head_slot];
      r.out_y = ring_y[head_slot];
      r.out_z = ring_z[head_slot];
    end else begin
      found = 0;
      for (int unsigned k = 0; k + 1 < fill && !found; k++) begin
        a = ring_slot(k);
        b = ring_slot(k + 1);
        if (t >= ring_time[a] && t < ring_time[b]) begin
          num = {32'd0, t - ring_time[a]} << 16;
          den = {32'd0, ring_time[b] - ring_time[a]};
          alpha = 16'(num / den);
          r.out_x = blend_axis(ring_x[a], ring_x[b], alpha);
          r.out_y = blend_axis(ring_y[a], ring_y[b], alpha);
          r.out_z = blend_axis(ring_z[a], ring_z[b], alpha);
          found = 1;
        end
      end
      if (!found) begin
        a = ring_slot(fill - 1);
        r.out_x = ring_x[a];
        r.out_y = ring_y[a];
        r.out_z = ring_z[a];
      end
    end
    expected_positions.push_back(r);
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Overall time limit: the worst run, ~1800 items with their gaps, stalls and
  // the hold-off, ends far below this.
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall per transaction while stall_randomly is set, with one long hold-off.
  initial begin
    int unsigned wait_cycles;
    out_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_hold > 0) begin
        out_stall <= 1'b1;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
      end
      wait_cycles = stall_randomly ? $urandom_range(0, 14) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker: a transaction is taken when valid is high and stall is low.
  always @(posedge clk) begin
    tphl_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        $error("unexpected result %p", out_data);
        error_count++;
      end else begin
        e = expected_positions.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x expected %h got %h", e.out_x, out_data.out_x);
          error_count++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y expected %h got %h", e.out_y, out_data.out_y);
          error_count++;
        end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z expected %h got %h", e.out_z, out_data.out_z);
          error_count++;
        end
        if (out_data.history_empty !== e.history_empty) begin
          $error("history_empty expected %b got %b", e.history_empty,
                 out_data.history_empty);
          error_count++;
        end
      end
    end
  end

  // Offers one item, after a random gap if gaps is set, and waits for its transaction.
  // Valid stays up afterwards so the next item can follow back to back.
  task automatic send_item(tphl_pkg::in_item_t it, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_history(it);
  endtask

  // Drains the block, then writes max_age while it is idle.
  task automatic set_max_age(logic [31:0] v);
    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (2 * HistDepth + 50) @(posedge clk);  // a record may still be aging
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    age_limit = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic tphl_pkg::in_item_t make_item(logic m, logic [31:0] t,
                                                   logic [31:0] n, logic [31:0] x,
                                                   logic [31:0] y, logic [31:0] z);
    tphl_pkg::in_item_t it;
    it.mode = m;
    it.sample_time = t;
    it.now_time = n;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  function automatic tphl_pkg::in_item_t random_item(logic [31:0] base_t, bit noise);
    logic [31:0] t;
    logic [31:0] n;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    t = noise ? $urandom() : base_t + $urandom_range(0, 300);
    n = noise ? $urandom() : t + $urandom_range(0, 400);
    return make_item(sel < 4 ? tphl_pkg::ModeQuery : tphl_pkg::ModeRecord,
                     (sel == 0 && !noise) ? base_t - $urandom_range(0, 2000) : t,
                     n, $urandom(), $urandom(), $urandom());
  endfunction

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    logic [31:0] clock_t;
    logic [31:0] limits[5];
    int unsigned phase;
    row = '{default: '0};

    error_count = 0;
    stall_hold = 0;
    stall_randomly = 1;
    age_limit = tphl_pkg::MaxAgeReset;
    head_slot = 0;
    fill = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty query, clamping, extremes, interpolation, aging cases.
    row.has_fixed = 1;
    row.fixed = '{out_x: 0, out_y: 0, out_z: 0, history_empty: 1'b1};
    row.item = make_item(tphl_pkg::ModeQuery, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0);
    rows.push_back(row);
    row.has_fixed = 0;
    row.item = make_item(tphl_pkg::ModeRecord, 100, 100, 32'h8000_0000, 32'h7FFF_FFFF,
                         0);
    rows.push_back(row);
    row.has_fixed = 1;
    row.fixed = '{out_x: 32'h8000_0000, out_y: 32'h7FFF_FFFF, out_z: 0,
                  history_empty: 1'b0};
    row.item = make_item(tphl_pkg::ModeQuery, 0, 0, 0, 0, 0);  // before the oldest
    rows.push_back(row);
    row.has_fixed = 0;
    row.item = make_item(tphl_pkg::ModeRecord, 200, 200, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'hFFFF_FFFF);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 150, 0, 0, 0, 0);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 199, 0, 0, 0, 0);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 101, 0, 0, 0, 0);
    rows.push_back(row);
    row.has_fixed = 1;  // past the newest: newest position
    row.fixed = '{out_x: 32'h7FFF_FFFF, out_y: 32'h8000_0000, out_z: 32'hFFFF_FFFF,
                  history_empty: 1'b0};
    row.item = make_item(tphl_pkg::ModeQuery, 32'hFFFF_FFFF, 0, 0, 0, 0);
    rows.push_back(row);
    row.has_fixed = 0;
    // Unordered timestamp, then a future sample relative to now.
    row.item = make_item(tphl_pkg::ModeRecord, 150, 210, 32'h0000_0100, 32'hFFFF_FF00,
                         5);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 175, 0, 0, 0, 0);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeRecord, 32'hFFFF_FFFF, 300, 1, 2, 3);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 32'h8000_0000, 0, 0, 0, 0);
    rows.push_back(row);
    // Aging drops the old entries; the future-stamped one has age zero and stays.
    row.item = make_item(tphl_pkg::ModeRecord, 0, 32'hFFFF_FFFF, 7, 8, 9);
    rows.push_back(row);
    row.has_fixed = 1;  // at or before the oldest: oldest position
    row.fixed = '{out_x: 1, out_y: 2, out_z: 3, history_empty: 1'b0};
    row.item = make_item(tphl_pkg::ModeQuery, 5, 0, 0, 0, 0);
    rows.push_back(row);
    row.has_fixed = 0;
    row.item = make_item(tphl_pkg::ModeRecord, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'h8000_0000);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeRecord, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0,
                         32'h7FFF_FFFF);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 32'hFFFF_FFFE, 0, 0, 0, 0);
    rows.push_back(row);
    row.item = make_item(tphl_pkg::ModeQuery, 32'h0000_0001, 0, 0, 0, 0);
    rows.push_back(row);

    foreach (rows[i]) begin
      send_item(rows[i].item, 1);
      if (rows[i].has_fixed) begin
        // Replace the prediction with the value read off the spec directly.
        expected_positions[expected_positions.size() - 1] = rows[i].fixed;
      end
    end

    // Fill the ring up to DEPTH entries, under a long receiver hold-off.
    stall_hold = 600;
    clock_t = 1000;
    for (int i = 0; i < 90; i++) begin
      send_item(make_item(i % 3 == 0 ? tphl_pkg::ModeQuery : tphl_pkg::ModeRecord,
                          clock_t, clock_t, $urandom(), $urandom(), $urandom()), 0);
      clock_t += 10;
    end

    // Random phases across several age limits, extremes included.
    limits = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'd5000, tphl_pkg::MaxAgeReset};
    for (phase = 0; phase < 5; phase++) begin
      set_max_age(limits[phase]);
      stall_randomly = (phase != 2);  // one phase without receiver stalls
      clock_t = $urandom();
      for (int i = 0; i < 340; i++) begin
        send_item(random_item(clock_t, $urandom_range(0, 9) == 0),
                  !(phase == 2 && i < 100));
        clock_t += $urandom_range(0, 200);
      end
    end

    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (2 * HistDepth + 50) @(posedge clk);
    if (error_count == 0 && expected_positions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* timestamped_position_history_lerp.f */
+incdir+rtl
rtl/tphl_pkg.sv
rtl/timestamped_position_history_lerp.sv
dv/timestamped_position_history_lerp_tb.sv
